// File: src/i2c_slave_command_deframer_defines.svh
// assertion macros for the two-wire slave command deframer
// no dependencies; included by the top level only
`ifndef I2C_SLAVE_COMMAND_DEFRAMER_DEFINES_SVH
`define I2C_SLAVE_COMMAND_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ISCD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, checked outside reset
`define ISCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// File: src/iscd_pkg.sv
// shared types and constants for the two-wire slave command deframer
// no dependencies
`timescale 1ns / 1ps

package iscd_pkg;

    // frame geometry
    localparam int FRAME_LEN = 6;
    localparam int SHORT_LEN = 2;
    localparam int OUT_BYTES = 6;
    localparam int PAD_LEN   = (FRAME_LEN > OUT_BYTES) ? FRAME_LEN : OUT_BYTES;
    localparam int COUNT_W   = $clog2(FRAME_LEN + 1);
    localparam int IDX_W     = $clog2(FRAME_LEN);

    typedef logic [7:0] byte_t;

    // bus event status codes, low three bits masked off
    localparam byte_t STATUS_MASK = 8'hF8;
    localparam byte_t ST_OWN_W    = 8'h60;
    localparam byte_t ST_OWN_W_AL = 8'h68;
    localparam byte_t ST_DATA     = 8'h80;
    localparam byte_t ST_DATA_NAK = 8'h88;
    localparam byte_t ST_GC_DATA  = 8'h90;
    localparam byte_t ST_GC_NAK   = 8'h98;
    localparam byte_t ST_STOP     = 8'hA0;

    // keypress frame fixed parameters
    localparam byte_t KEY_PAR   = 8'd128;
    localparam byte_t KEY_EXTRA = 8'd2;

    // register reset values
    localparam byte_t KEYPRESS_RESET = 8'd255;
    localparam byte_t LOGO_RESET     = 8'd74;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEYPRESS_CODE,
        CFG_LOGO_KEY
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_LED,
        KIND_KEY,
        KIND_LOGO,
        KIND_DILUTE
    } kind_t;

    typedef struct packed {
        byte_t keypress_code;
        byte_t logo_key;
    } cfg_t;

    typedef struct packed {
        byte_t status_code;
        byte_t data_byte;
    } event_t;

    typedef struct packed {
        logic  receiving;
        logic  frame_done;
        kind_t frame_kind;
        byte_t command;
        byte_t target;
        byte_t red;
        byte_t green;
        byte_t blue;
        byte_t extra;
    } result_t;

endpackage

// File: src/iscd_frame.sv
// frame state and command decode for one bus event per cycle while step is high
// depends on iscd_pkg
`timescale 1ns / 1ps

module iscd_frame
    import iscd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  event_t  ev,
    input  cfg_t    cfg,
    output result_t res
);

    logic               accepting_reg, accepting_next;
    logic [COUNT_W-1:0] count_reg, count_next, count_inc, frame_len;
    byte_t              bytes_reg [FRAME_LEN];
    byte_t              bytes_view [FRAME_LEN];
    byte_t              padded [PAD_LEN];
    byte_t              stat;
    logic               is_own, is_data, is_gc, is_stop;
    logic               store, short_frame, done;

    // status decode
    always_comb begin
        stat    = ev.status_code & STATUS_MASK;
        is_own  = 1'b0;
        is_data = 1'b0;
        is_gc   = 1'b0;
        is_stop = 1'b0;
        case (stat)
            ST_OWN_W, ST_OWN_W_AL: begin
                is_own = 1'b1;
            end
            ST_DATA, ST_DATA_NAK: begin
                is_data = 1'b1;
            end
            ST_GC_DATA, ST_GC_NAK: begin
                is_data = 1'b1;
                is_gc   = 1'b1;
            end
            ST_STOP: begin
                is_stop = 1'b1;
            end
            default: begin
                is_own = 1'b0;
            end
        endcase
    end

    // frame bytes as they stand after this event
    always_comb begin
        store = is_data && accepting_reg;
        for (int i = 0; i < FRAME_LEN; i++) begin
            bytes_view[i] = (store && count_reg == COUNT_W'(i)) ? ev.data_byte : bytes_reg[i];
        end
        for (int i = 0; i < PAD_LEN; i++) begin
            padded[i] = '0;
        end
        for (int i = 0; i < FRAME_LEN; i++) begin
            padded[i] = bytes_view[i];
        end
    end

    // length check against the current keypress code
    always_comb begin
        count_inc   = count_reg + 1'b1;
        short_frame = (bytes_view[0] == cfg.keypress_code);
        frame_len   = short_frame ? COUNT_W'(SHORT_LEN) : COUNT_W'(FRAME_LEN);
        done        = store && (count_inc >= frame_len);
    end

    // next state
    always_comb begin
        accepting_next = accepting_reg;
        count_next     = count_reg;
        if (is_own) begin
            accepting_next = 1'b1;
            count_next     = '0;
        end else if (store) begin
            count_next = done ? '0 : count_inc;
        end
        if (done || is_gc || is_stop) begin
            accepting_next = 1'b0;
        end
    end

    // result word
    always_comb begin
        res            = '0;
        res.receiving  = accepting_next;
        res.frame_done = done;
        if (done) begin
            res.command = padded[0];
            res.target  = padded[1];
            if (short_frame) begin
                res.frame_kind = (padded[1] == cfg.logo_key) ? KIND_LOGO : KIND_DILUTE;
                res.red        = KEY_PAR;
                res.green      = KEY_PAR;
                res.blue       = KEY_PAR;
                res.extra      = KEY_EXTRA;
            end else begin
                res.frame_kind = padded[0][7] ? KIND_KEY : KIND_LED;
                res.red        = padded[2];
                res.green      = padded[3];
                res.blue       = padded[4];
                res.extra      = padded[5];
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accepting_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < FRAME_LEN; i++) begin
                bytes_reg[i] <= '0;
            end
        end else if (step) begin
            accepting_reg <= accepting_next;
            count_reg     <= count_next;
            if (store) begin
                bytes_reg[count_reg[IDX_W-1:0]] <= ev.data_byte;
            end
        end
    end

endmodule

// File: src/i2c_slave_command_deframer.sv
// two-wire slave command deframer: each word is held in the input register, then in the output register
// throughput one word per cycle while m_tready does not stall the output; one result word per input word
// input register, decode against frame state, output register; stalls propagate back
// aresetn (synchronous) clears the frame state, valid flags and config to reset values
// depends on iscd_pkg, iscd_frame and the defines header
`timescale 1ns / 1ps
`include "i2c_slave_command_deframer_defines.svh"

module i2c_slave_command_deframer
    import iscd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // status_code [7:0], data_byte [15:8]
    input  logic [15:0]          s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // receiving [0], command [8:1], target [16:9], red [24:17], green [32:25],
    // blue [40:33], extra [48:41], zero fill [55:49]
    output logic [55:0]          m_tdata,
    // frame_kind [1:0]
    output logic [1:0]           m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t    cfg_reg;
    logic    in_valid_reg, out_valid_reg;
    event_t  in_data_reg;
    result_t res, res_reg;
    logic    advance, proc;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.keypress_code <= KEYPRESS_RESET;
            cfg_reg.logo_key      <= LOGO_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_KEYPRESS_CODE: cfg_reg.keypress_code <= cfg_data;
                CFG_LOGO_KEY:      cfg_reg.logo_key      <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // handshake between the two register stages
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg.status_code <= s_tdata[7:0];
            in_data_reg.data_byte   <= s_tdata[15:8];
        end
    end

    // frame state and decode
    iscd_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc),
        .ev      (in_data_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            res_reg <= res;
        end
    end

    // output word packing
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.frame_done;
    assign m_tuser  = res_reg.frame_kind;
    assign m_tdata  = {7'b0, res_reg.extra, res_reg.blue, res_reg.green, res_reg.red,
                       res_reg.target, res_reg.command, res_reg.receiving};

    // checks
    `ISCD_ASSERT_NEXT(a_in_to_stage, aclk, aresetn, s_tvalid && s_tready, in_valid_reg)
    `ISCD_ASSERT_NEXT(a_stage_to_out, aclk, aresetn, in_valid_reg && advance, m_tvalid)
    `ISCD_ASSERT_IMPL(a_stall_full, aclk, aresetn, !s_tready, in_valid_reg && m_tvalid && !m_tready)
    `ISCD_ASSERT_IMPL(a_done_idle, aclk, aresetn, m_tvalid && m_tlast, !m_tdata[0])

endmodule

// File: verif/i2c_slave_command_deframer_tb.sv
// self-checking testbench for the two-wire slave command deframer
// drives bus event words, predicts every result word in a scoreboard class and compares
// depends on iscd_pkg and the i2c_slave_command_deframer rtl
`timescale 1ns / 1ps

module i2c_slave_command_deframer_tb;
    import iscd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int PHASE_EVENTS = 50;
    localparam int DRAIN_CYCLES = 8;

    // frame tracker: mirrors the deframer state and holds the expected result words
    class command_tracker;
        byte_t       keypress_code;
        byte_t       logo_key;
        bit          accepting;
        int unsigned count;
        byte_t       frame_mem [FRAME_LEN];
        result_t     expected_q [$];
        int          mismatches;

        function new();
            keypress_code = KEYPRESS_RESET;
            logo_key      = LOGO_RESET;
            accepting     = 1'b0;
            count         = 0;
            foreach (frame_mem[i]) frame_mem[i] = '0;
            mismatches    = 0;
        endfunction

        // bytes past the stored frame read as zero
        function byte_t byte_at(int unsigned idx);
            return (idx < FRAME_LEN) ? frame_mem[idx] : '0;
        endfunction

        // work out the result word caused by one accepted event word
        function void note_event(byte_t status_code, byte_t data_byte);
            byte_t       st;
            bit          done;
            int unsigned flen;
            result_t     r;
            st   = status_code & STATUS_MASK;
            done = 1'b0;
            r    = '0;
            case (st)
                ST_OWN_W, ST_OWN_W_AL: begin
                    count     = 0;
                    accepting = 1'b1;
                end
                ST_DATA, ST_DATA_NAK, ST_GC_DATA, ST_GC_NAK: begin
                    if (accepting) begin
                        if (count < FRAME_LEN) frame_mem[count] = data_byte;
                        count++;
                        // length is rechecked on every byte with the current register
                        flen = (frame_mem[0] == keypress_code) ? SHORT_LEN : FRAME_LEN;
                        if (count >= flen) begin
                            done      = 1'b1;
                            accepting = 1'b0;
                        end
                    end
                    if (st == ST_GC_DATA || st == ST_GC_NAK) accepting = 1'b0;
                end
                ST_STOP: accepting = 1'b0;
                default: ;
            endcase

            if (done) begin
                r.command = frame_mem[0];
                r.target  = frame_mem[1];
                if (frame_mem[0] == keypress_code) begin
                    r.frame_kind = (frame_mem[1] == logo_key) ? KIND_LOGO : KIND_DILUTE;
                    r.red        = KEY_PAR;
                    r.green      = KEY_PAR;
                    r.blue       = KEY_PAR;
                    r.extra      = KEY_EXTRA;
                end else begin
                    r.frame_kind = (frame_mem[0] < 8'd128) ? KIND_LED : KIND_KEY;
                    r.red        = byte_at(2);
                    r.green      = byte_at(3);
                    r.blue       = byte_at(4);
                    r.extra      = byte_at(5);
                end
                count = 0;
            end
            r.receiving  = accepting;
            r.frame_done = done;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("result word with no expectation pending");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            check_field("receiving", want.receiving, got.receiving);
            check_field("frame_done", want.frame_done, got.frame_done);
            check_field("frame_kind", want.frame_kind, got.frame_kind);
            check_field("command", want.command, got.command);
            check_field("target", want.target, got.target);
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("extra", want.extra, got.extra);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic [15:0]          s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [55:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    command_tracker tracker = new();
    bit             no_gaps = 1'b0;
    int             sent    = 0;

    i2c_slave_command_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 3);
    endfunction

    // present one event word and hold it until accepted
    task automatic send_event(byte_t status_code, byte_t data_byte);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {data_byte, status_code};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_event(status_code, data_byte);
        sent++;
    endtask

    // stop sending and wait until every expected word has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write both registers while the block is idle
    task automatic set_config(byte_t kp, byte_t logo);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_KEYPRESS_CODE;
        cfg_data  <= kp;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_LOGO_KEY;
        cfg_data  <= logo;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.keypress_code = kp;
        tracker.logo_key      = logo;
        @(posedge aclk);
    endtask

    // one own-address write followed by a frame, sometimes broken off
    task automatic send_frame();
        byte_t       cmd;
        byte_t       data;
        byte_t       base;
        int unsigned flen;
        int          pick;
        base = $urandom_range(0, 1) ? ST_OWN_W : ST_OWN_W_AL;
        send_event(base | byte_t'($urandom_range(0, 7)), byte_t'($urandom_range(0, 255)));
        cmd  = ($urandom_range(0, 9) < 4) ? tracker.keypress_code
                                          : byte_t'($urandom_range(0, 255));
        flen = (cmd == tracker.keypress_code) ? SHORT_LEN : FRAME_LEN;
        for (int i = 0; i < flen; i++) begin
            if (i == 0)
                data = cmd;
            else if (i == 1 && flen == SHORT_LEN && $urandom_range(0, 1))
                data = tracker.logo_key;
            else
                data = byte_t'($urandom_range(0, 255));
            pick = $urandom_range(0, 15);
            if (pick == 0)      base = ST_GC_DATA;
            else if (pick == 1) base = ST_GC_NAK;
            else if (pick == 2) base = ST_STOP;
            else if (pick < 9)  base = ST_DATA_NAK;
            else                base = ST_DATA;
            send_event(base | byte_t'($urandom_range(0, 7)), data);
        end
        if ($urandom_range(0, 1))
            send_event(ST_STOP | byte_t'($urandom_range(0, 7)), byte_t'($urandom_range(0, 255)));
    endtask

    // result side: random stalls, capture on every accepted word
    initial begin
        int      gap;
        result_t got;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.receiving  = m_tdata[0];
            got.frame_done = m_tlast;
            got.frame_kind = kind_t'(m_tuser);
            got.command    = m_tdata[8:1];
            got.target     = m_tdata[16:9];
            got.red        = m_tdata[24:17];
            got.green      = m_tdata[32:25];
            got.blue       = m_tdata[40:33];
            got.extra      = m_tdata[48:41];
            tracker.check_result(got);
        end
    end

    // stimulus
    initial begin
        byte_t kp_list   [8];
        byte_t logo_list [8];
        int    phase_end;
        kp_list   = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0};
        logo_list = '{8'd0, 8'd255, 8'd1, 8'd74, 8'd0, 8'd0, 8'd0, 8'd0};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_KEYPRESS_CODE;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle events, led, logo, dilute, key frame cut by general call, stop
        send_event(ST_STOP | 8'h07, 8'h00);
        send_event(ST_DATA, 8'hff);
        send_event(8'h00, 8'haa);
        send_event(ST_OWN_W | 8'h03, 8'h55);
        send_event(ST_DATA, 8'h00);
        send_event(ST_DATA_NAK | 8'h05, 8'hff);
        send_event(ST_DATA, 8'h80);
        send_event(ST_DATA, 8'h7f);
        send_event(ST_DATA, 8'h01);
        send_event(ST_DATA, 8'hfe);
        send_event(ST_OWN_W_AL | 8'h07, 8'h00);
        send_event(ST_DATA, 8'hff);
        send_event(ST_GC_NAK | 8'h07, LOGO_RESET);
        send_event(ST_OWN_W, 8'h00);
        send_event(ST_DATA, 8'hff);
        send_event(ST_DATA, 8'h00);
        send_event(ST_OWN_W_AL, 8'h00);
        send_event(ST_DATA, 8'h80);
        send_event(ST_GC_DATA, 8'h11);
        send_event(ST_DATA, 8'h22);
        send_event(ST_OWN_W, 8'h00);
        send_event(ST_DATA, 8'hc3);
        send_event(ST_STOP, 8'h00);
        send_event(ST_DATA, 8'h44);
        send_event(8'hf8, 8'hff);

        // open frame, then keypress code changed to its first byte mid-frame
        send_event(ST_OWN_W, 8'h00);
        send_event(ST_DATA, 8'h3c);
        set_config(8'h3c, LOGO_RESET);
        send_event(ST_DATA, 8'h05);

        // random phases, extremes first then random register values
        for (int p = 0; p < 8; p++) begin
            if (p >= 4) begin
                kp_list[p]   = byte_t'($urandom_range(0, 255));
                logo_list[p] = byte_t'($urandom_range(0, 255));
            end
            set_config(kp_list[p], logo_list[p]);
            no_gaps   = ($urandom_range(0, 3) == 0);
            phase_end = sent + PHASE_EVENTS;
            while (sent < phase_end) begin
                if ($urandom_range(0, 4) == 0)
                    send_event(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
                else
                    send_frame();
            end
        end
        no_gaps = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
